// ===== rtl/tsgsb_pkg.sv =====
// ----------------------------------------------------------------------------
// tsgsb_pkg
// Shared types and constants for the time sorting gap split buffer.
// ----------------------------------------------------------------------------
package tsgsb_pkg;
  localparam int StoreDepth = 32;
  localparam int IdxW = $clog2(StoreDepth);
  localparam int CntW = $clog2(StoreDepth + 1);
  localparam int TsW = 48;
  localparam int CorrW = 16;
  localparam int PayW = 64;
  // ts*256 plus a positive correction can pass 2^56, so one guard bit over sign
  localparam int KeyW = TsW + 10;

  localparam logic [0:0] OP_INSERT = 1'b0;
  localparam logic [0:0] OP_FLUSH = 1'b1;

  localparam logic [0:0] CFG_HOLD = 1'b0;
  localparam logic [0:0] CFG_GAP = 1'b1;

  typedef struct packed {
    logic [TsW-1:0] ts;
    logic signed [CorrW-1:0] corr;
    logic [PayW-1:0] pay;
  } word_t;

  // per-cycle command from controller to every cell
  typedef struct packed {
    logic ins;        // sorted insert of new word
    logic shift;      // pop front: each cell takes its right neighbor
  } cell_cmd_t;

  function automatic logic signed [KeyW-1:0] key_of(word_t w);
    key_of = $signed({2'b00, w.ts, 8'd0}) + KeyW'(w.corr);
  endfunction
endpackage

// ===== rtl/tsgsb_cell.sv =====
// ----------------------------------------------------------------------------
// tsgsb_cell
// One store slot: holds a word, compares against the new key, shifts.
// ----------------------------------------------------------------------------
module tsgsb_cell
  import tsgsb_pkg::*;
(
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  word_t     new_word,
  input  logic      occupied,    // slot below stored count
  input  logic      left_gt,     // left neighbor key > new key (and occupied)
  input  word_t     left_word,
  input  word_t     right_word,
  output word_t     word_q,
  output logic      gt           // this key > new key, slot occupied
);
  word_t word_r, word_nxt;

  assign gt = occupied && (key_of(word_r) > key_of(new_word));

  always_comb begin
    word_nxt = word_r;
    if (cmd.shift) begin
      word_nxt = right_word;
    end else if (cmd.ins) begin
      if (left_gt) begin
        word_nxt = left_word;
      end else if (gt || !occupied) begin
        word_nxt = new_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_q = word_r;
endmodule

// ===== rtl/time_sorting_gap_split_buffer_top.sv =====
// ----------------------------------------------------------------------------
// time_sorting_gap_split_buffer_top
// Timestamp sorting reorder buffer with gap-split batch emission.
// ----------------------------------------------------------------------------
// Usage: words enter on the in_ channel (valid/stall); results leave on the
// out_ channel, one word per cycle from the front of a row of storage cells.
// Configuration is written on cfg_ while idle: index 0 hold_count, index 1
// gap_threshold.
// An insert that emits nothing is accepted, then every cell compares and
// shifts in parallel in S_INS. When a chunk starts, a gap scan walks the
// stored pairs from hold_count; for each pair it registers the key
// difference, then compares. The batch then drains at one word per cycle;
// a full store drains first. A flush drains all words.
// The output register holds its word while out_stall is high; the block
// simply waits. in_stall is high whenever an item is in progress.
// Reset empties the store and restores hold_count 16, gap_threshold 50000.
// ----------------------------------------------------------------------------
module time_sorting_gap_split_buffer_top
  import tsgsb_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [0:0]              cfg_index,
  input  logic [31:0]             cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_operation,
  input  logic [TsW-1:0]          in_timestamp,
  input  logic signed [CorrW-1:0] in_cfd_correction,
  input  logic [PayW-1:0]         in_payload,
  input  logic                    in_chunk_end,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_entry_valid,
  output logic [TsW-1:0]          out_timestamp,
  output logic signed [CorrW-1:0] out_out_cfd_correction,
  output logic [PayW-1:0]         out_payload,
  output logic                    out_last_of_batch,
  output logic                    out_end_of_stream
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FULL  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_EMIT  = 6'b001000,
    S_INS   = 6'b010000,
    S_FLUSH = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [4:0] hold_r;
  logic [31:0] gap_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [CntW-1:0] left_r, left_nxt;   // words still to emit in batch
  logic [CntW-1:0] scan_r, scan_nxt;   // scan position i
  logic pend_r, pend_nxt;
  logic op_r, ce_r;
  word_t new_r;
  logic ov_r, ov_nxt, oe_r, oe_nxt, ol_r, ol_nxt, oeos_r, oeos_nxt;
  word_t ow_r, ow_nxt;
  cell_cmd_t cmd;
  word_t cw [StoreDepth];
  logic  cg [StoreDepth];
  logic signed [KeyW:0] diff_r;
  logic diff_v_r;
  logic out_free;

  genvar g;
  generate
    for (g = 0; g < StoreDepth; g++) begin : g_cell
      tsgsb_cell u_cell (
        .clk(clk), .cmd(cmd), .new_word(new_r),
        .occupied(CntW'(g) < cnt_r),
        .left_gt((g == 0) ? 1'b0 : cg[(g == 0) ? 0 : g - 1]),
        .left_word(cw[(g == 0) ? 0 : g - 1]),
        .right_word(cw[(g == StoreDepth - 1) ? g : g + 1]),
        .word_q(cw[g]), .gt(cg[g])
      );
    end
  endgenerate

  assign out_free = !ov_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  // registered key difference of pair (scan, scan+1)
  always_ff @(posedge clk) begin
    diff_r <= (KeyW+1)'(key_of(cw[scan_r[IdxW-1:0] + IdxW'(1)]))
            - (KeyW+1)'(key_of(cw[scan_r[IdxW-1:0]]));
  end

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; left_nxt = left_r; scan_nxt = scan_r;
    pend_nxt = pend_r; cmd = '0;
    ov_nxt = ov_r && out_stall; oe_nxt = oe_r; ol_nxt = ol_r; oeos_nxt = oeos_r;
    ow_nxt = ow_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_operation == OP_FLUSH) begin
            state_nxt = S_FLUSH; left_nxt = cnt_r;
          end else if (cnt_r == CntW'(StoreDepth)) begin
            state_nxt = S_FULL; left_nxt = cnt_r;
          end else if (pend_r && cnt_r > CntW'(hold_r)) begin
            state_nxt = S_SCAN; scan_nxt = CntW'(hold_r);
          end else begin
            state_nxt = S_INS;
          end
        end
      end
      S_FULL, S_EMIT, S_FLUSH: begin
        if (left_r == '0) begin
          if (state_r == S_FLUSH) begin
            if (out_free) begin
              ov_nxt = 1'b1; oe_nxt = 1'b0; ow_nxt = '0; ol_nxt = 1'b1;
              oeos_nxt = 1'b1; state_nxt = S_IDLE; pend_nxt = 1'b1;
            end
          end else if (state_r == S_FULL && pend_r && cnt_r > CntW'(hold_r)) begin
            state_nxt = S_SCAN; scan_nxt = CntW'(hold_r);
          end else begin
            state_nxt = S_INS;
          end
        end else if (out_free) begin
          ov_nxt = 1'b1; oe_nxt = 1'b1; ow_nxt = cw[0];
          ol_nxt = (left_r == CntW'(1));
          oeos_nxt = (state_r == S_FLUSH) && (left_r == CntW'(1));
          cmd.shift = 1'b1; cnt_nxt = cnt_r - CntW'(1); left_nxt = left_r - CntW'(1);
          if (state_r == S_FLUSH && left_r == CntW'(1)) begin
            state_nxt = S_IDLE; pend_nxt = 1'b1;
          end
        end
      end
      S_SCAN: begin
        // diff of current pair is registered next cycle
        if (scan_r + CntW'(1) >= cnt_r) begin
          state_nxt = S_EMIT; left_nxt = cnt_r;
        end else if (diff_v_r && diff_r > $signed({1'b0, gap_r, 8'd0})) begin
          state_nxt = S_EMIT; left_nxt = scan_r;
        end else if (diff_v_r) begin
          scan_nxt = scan_r + CntW'(1);
        end
      end
      S_INS: begin
        if (op_r == OP_INSERT) begin
          cmd.ins = 1'b1; cnt_nxt = cnt_r + CntW'(1); pend_nxt = ce_r;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; pend_r <= 1'b1; ov_r <= 1'b0;
      hold_r <= 5'd16; gap_r <= 32'd50000; diff_v_r <= 1'b0;
      left_r <= '0; scan_r <= '0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; pend_r <= pend_nxt; ov_r <= ov_nxt;
      left_r <= left_nxt; scan_r <= scan_nxt;
      diff_v_r <= (state_r == S_SCAN) && (scan_nxt == scan_r) && !diff_v_r;
      if (cfg_we && cfg_index == CFG_HOLD) hold_r <= cfg_data[4:0];
      if (cfg_we && cfg_index == CFG_GAP) gap_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    oe_r <= oe_nxt; ol_r <= ol_nxt; oeos_r <= oeos_nxt; ow_r <= ow_nxt;
    if (state_r == S_IDLE && in_valid) begin
      op_r <= in_operation; ce_r <= in_chunk_end;
      new_r <= '{ts: in_timestamp, corr: in_cfd_correction, pay: in_payload};
    end
  end

  assign out_valid = ov_r;
  assign out_entry_valid = oe_r;
  assign out_timestamp = ow_r.ts;
  assign out_out_cfd_correction = ow_r.corr;
  assign out_payload = ow_r.pay;
  assign out_last_of_batch = ol_r;
  assign out_end_of_stream = oeos_r;
endmodule

// ===== dv/time_sorting_gap_split_buffer_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// time_sorting_gap_split_buffer_top_tb
// Self-checking bench: drives detector words and flushes with random gaps and
// output stalls, keeps its own sorted store and gap-split rules, and compares
// every emitted word field by field in order.
// ----------------------------------------------------------------------------
module time_sorting_gap_split_buffer_top_tb;
  import tsgsb_pkg::*;

  localparam int WatchLimit = 5000;
  localparam int SettleCycles = 120;

  typedef struct {
    logic       ev;
    word_t      w;
    logic       lob;
    logic       eos;
  } emitted_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [0:0]              cfg_index;
  logic [31:0]             cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_operation;
  logic [TsW-1:0]          in_timestamp;
  logic signed [CorrW-1:0] in_cfd_correction;
  logic [PayW-1:0]         in_payload;
  logic                    in_chunk_end;
  logic                    out_valid;
  logic                    out_stall;
  logic                    out_entry_valid;
  logic [TsW-1:0]          out_timestamp;
  logic signed [CorrW-1:0] out_out_cfd_correction;
  logic [PayW-1:0]         out_payload;
  logic                    out_last_of_batch;
  logic                    out_end_of_stream;

  time_sorting_gap_split_buffer_top dut (.*);

  // sorted store kept by the bench, and what it still owes
  word_t       sorted_words[$];
  emitted_t    pending_out[$];
  logic        chunk_open;
  int unsigned hold_cnt;
  logic [31:0] gap_ticks;
  int          err_cnt;
  int          idle_cnt;
  logic        quiet;
  logic [TsW-1:0] base_ts;

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  function automatic longint fine_time(word_t w);
    return longint'(w.ts) * 256 + longint'(w.corr);
  endfunction

  function automatic void emit_front(int n, logic eos);
    emitted_t r;
    for (int i = 0; i < n; i++) begin
      r.ev = 1'b1;
      r.w = sorted_words[0];
      r.lob = (i + 1 == n);
      r.eos = eos && (i + 1 == n);
      pending_out.push_back(r);
      sorted_words.delete(0);
    end
  endfunction

  function automatic void predict_item(logic op, word_t w, logic ce);
    emitted_t r;
    int stop;
    int p;
    if (op == OP_FLUSH) begin
      if (sorted_words.size() == 0) begin
        r.ev = 1'b0; r.w = '0; r.lob = 1'b1; r.eos = 1'b1;
        pending_out.push_back(r);
      end else begin
        emit_front(sorted_words.size(), 1'b1);
      end
      chunk_open = 1'b1;
      return;
    end
    if (sorted_words.size() >= StoreDepth) emit_front(sorted_words.size(), 1'b0);
    if (chunk_open && sorted_words.size() > hold_cnt) begin
      stop = sorted_words.size();
      for (int i = hold_cnt; i + 1 < sorted_words.size(); i++) begin
        if (fine_time(sorted_words[i+1]) - fine_time(sorted_words[i]) >
            longint'(gap_ticks) * 256) begin
          stop = i;
          break;
        end
      end
      emit_front(stop, 1'b0);
    end
    p = sorted_words.size();
    while (p > 0 && fine_time(sorted_words[p-1]) > fine_time(w)) p--;
    sorted_words.insert(p, w);
    chunk_open = ce;
  endfunction

  // result checker and watchdog
  always @(posedge clk) begin
    emitted_t e;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WatchLimit) begin
        $display("time_sorting_gap_split_buffer_top_tb: done, errors");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pending_out.size() == 0) begin
          $error("unexpected result transfer");
          err_cnt++;
        end else begin
          e = pending_out.pop_front();
          if (out_entry_valid !== e.ev) begin
            $error("entry_valid exp %0h got %0h", e.ev, out_entry_valid); err_cnt++;
          end
          if (out_timestamp !== e.w.ts) begin
            $error("out_timestamp exp %0h got %0h", e.w.ts, out_timestamp); err_cnt++;
          end
          if (out_out_cfd_correction !== e.w.corr) begin
            $error("out_cfd_correction exp %0d got %0d", e.w.corr,
                   out_out_cfd_correction);
            err_cnt++;
          end
          if (out_payload !== e.w.pay) begin
            $error("out_payload exp %0h got %0h", e.w.pay, out_payload); err_cnt++;
          end
          if (out_last_of_batch !== e.lob) begin
            $error("last_of_batch exp %0h got %0h", e.lob, out_last_of_batch);
            err_cnt++;
          end
          if (out_end_of_stream !== e.eos) begin
            $error("end_of_stream exp %0h got %0h", e.eos, out_end_of_stream);
            err_cnt++;
          end
        end
      end
    end
  end

  // receiver backpressure, one draw per result
  initial begin
    int n;
    @(negedge clk);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 9);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  // called at a falling edge; returns at a falling edge with valid still high
  task automatic send_item(logic op, logic [TsW-1:0] ts, logic signed [CorrW-1:0] corr,
                           logic [PayW-1:0] pay, logic ce);
    int gap;
    logic taken;
    word_t w;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_operation <= op;
    in_timestamp <= ts;
    in_cfd_correction <= corr;
    in_payload <= pay;
    in_chunk_end <= ce;
    in_valid <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      #1;
      taken = !in_stall;
      @(posedge clk);
      if (!taken) @(negedge clk);
    end
    w.ts = ts; w.corr = corr; w.pay = pay;
    predict_item(op, w, ce);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_out.size() != 0) @(negedge clk);
  endtask

  // inserts may still be sorting or scanning after the last result
  task automatic set_regs(int unsigned h, logic [31:0] g);
    wait_drained();
    repeat (SettleCycles) @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_HOLD; cfg_data <= h;
    @(negedge clk);
    cfg_index <= CFG_GAP; cfg_data <= g;
    @(negedge clk);
    cfg_we <= 1'b0;
    hold_cnt = h;
    gap_ticks = g;
  endtask

  task automatic test_directed();
    logic [TsW-1:0] tmax;
    tmax = '1;
    set_regs(16, 50000);
    send_item(OP_FLUSH, '1, '1, '1, 1'b1);                      // empty flush
    send_item(OP_INSERT, tmax, 16'sh7fff, '1, 1'b0);
    send_item(OP_INSERT, '0, -16'sh8000, '0, 1'b0);
    send_item(OP_INSERT, 48'd10, 16'sd0, 64'h1, 1'b0);
    send_item(OP_INSERT, 48'd9, 16'sd256, 64'h2, 1'b1);         // equal fine time
    send_item(OP_FLUSH, '0, '0, '0, 1'b0);
    set_regs(0, 0);
    send_item(OP_INSERT, 48'd100, 16'sd0, 64'hA, 1'b1);
    send_item(OP_INSERT, 48'd100, 16'sd1, 64'hB, 1'b1);        // gap after word 0
    send_item(OP_INSERT, 48'd100, 16'sd1, 64'hC, 1'b1);
    send_item(OP_INSERT, 48'd100, 16'sd1, 64'hD, 1'b1);
    set_regs(2, 10);
    send_item(OP_INSERT, 48'd1000, 16'sd0, 64'h10, 1'b0);
    send_item(OP_INSERT, 48'd1005, 16'sd0, 64'h11, 1'b0);
    send_item(OP_INSERT, 48'd1100, 16'sd0, 64'h12, 1'b0);       // gap at hold position
    send_item(OP_INSERT, 48'd1101, 16'sd0, 64'h13, 1'b1);
    send_item(OP_INSERT, 48'd1102, 16'sd0, 64'h14, 1'b1);
    send_item(OP_FLUSH, '0, '0, '0, 1'b1);
  endtask

  task automatic test_full_store();
    set_regs(31, 32'hFFFF_FFFF);
    for (int i = 0; i < StoreDepth + 3; i++)
      send_item(OP_INSERT, 48'($urandom_range(0, 5000)), 16'($urandom),
                {$urandom, $urandom}, 1'b0);
    send_item(OP_FLUSH, '0, '0, '0, 1'b1);
  endtask

  task automatic test_random(int n, int unsigned h, logic [31:0] g, logic calm);
    int pick;
    logic [TsW-1:0] ts;
    set_regs(h, g);
    quiet = calm;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (i == n / 2) wait_drained();
      if (pick < 5) begin
        send_item(OP_FLUSH, TsW'({$urandom, $urandom}), 16'($urandom),
                  {$urandom, $urandom}, 1'($urandom));
      end else begin
        if (pick < 15) ts = TsW'({$urandom, $urandom});
        else begin
          if ($urandom_range(0, 3) == 0) base_ts += 48'($urandom_range(0, 2 * (g % 5000) + 20));
          ts = base_ts + 48'($urandom_range(0, 8));
        end
        send_item(OP_INSERT, ts, 16'($urandom), {$urandom, $urandom},
                  $urandom_range(0, 2) == 0);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = CFG_HOLD; cfg_data = '0;
    in_valid = 1'b0; in_operation = OP_INSERT; in_timestamp = '0;
    in_cfd_correction = '0; in_payload = '0; in_chunk_end = 1'b0;
    out_stall = 1'b0;
    err_cnt = 0; idle_cnt = 0; quiet = 1'b0; base_ts = 48'h7FFF_FFF0_0000;
    chunk_open = 1'b1; hold_cnt = 16; gap_ticks = 50000;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_full_store();
    test_random(100, 2, 20, 1'b0);
    test_random(50, 0, 0, 1'b0);
    test_random(100, 5, 1000, 1'b1);
    test_random(60, 31, 32'hFFFF_FFFF, 1'b0);
    wait_drained();
    repeat (SettleCycles) @(negedge clk);
    if (err_cnt == 0 && pending_out.size() == 0) begin
      $display("time_sorting_gap_split_buffer_top_tb: done, clean");
    end else begin
      $display("time_sorting_gap_split_buffer_top_tb: done, errors");
    end
    $finish;
  end

endmodule
